>>> sv/double_ended_queue_top_assert.svh
// assertion macros for the double-ended queue
// used by double_ended_queue_top; expects clk and rst_n in scope
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define DQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dq assertion failed");
// next-cycle implication, checked outside reset
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dq assertion failed");
`else
`define DQ_ASSERT_IMPL(lbl, ante, cons)
`define DQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/dq_pkg.sv
// shared types and codes for the double-ended queue
// no dependencies; used by controller, datapath and top level
package dq_pkg;

    // operation codes carried in the input kind field
    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_CLEAR      = 3'd4,
        KIND_REVERSE    = 3'd5,
        KIND_QUERY      = 3'd6
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } stat_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic exec;   // apply the accepted operation to pointers and store
        logic read;   // read the low and high end slots
        logic load;   // load the result register
    } dq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } dq_sts_t;

endpackage

>>> sv/dq_ctrl.sv
// sequencing state machine for the double-ended queue
// depends on dq_pkg; drives the datapath through dq_cmd_t
module dq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  dq_pkg::dq_sts_t sts,
    output dq_pkg::dq_cmd_t cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = dq_pkg::ST_READ;
                end
            end
            dq_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = dq_pkg::ST_LOAD;
            end
            dq_pkg::ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/dq_datapath.sv
// pointers, word store and result register of the double-ended queue
// depends on dq_pkg; controlled by dq_ctrl through dq_cmd_t
module dq_datapath #(
    parameter int CAPACITY = 16,
    parameter int PTR_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dq_pkg::dq_cmd_t    cmd,
    output dq_pkg::dq_sts_t    sts,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    input  logic               m_tready,
    output logic               out_valid,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic [CNT_W-1:0]   occupancy,
    output logic               is_empty,
    output logic [1:0]         status
);

    localparam logic [PTR_W:0]   CAP_P   = (PTR_W + 1)'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);

    logic signed [31:0] word_store [CAPACITY];

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rev_reg, rev_next;
    dq_pkg::stat_t      stat_reg, stat_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [31:0] lo_q_reg, hi_q_reg;
    logic signed [31:0] front_reg, back_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic               empty_reg;
    logic [1:0]         status_reg;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   head_dec, head_inc, tail_slot, hi_slot;
    logic [CNT_W-1:0]   cnt_m1;
    logic               full, empty, to_low;
    dq_pkg::kind_t      op;

    // circular add of two slot offsets, sum stays below twice the capacity
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_P)
        begin
            s = s - CAP_P;
        end
        return s[PTR_W-1:0];
    endfunction

    // slot arithmetic
    assign full      = (count_reg == CAP_C);
    assign empty     = (count_reg == '0);
    assign head_dec  = (head_reg == '0) ? LAST_P : head_reg - PTR_W'(1);
    assign head_inc  = (head_reg == LAST_P) ? '0 : head_reg + PTR_W'(1);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign tail_slot = wrap_add(head_reg, count_reg[PTR_W-1:0]);
    assign hi_slot   = wrap_add(head_reg, cnt_m1[PTR_W-1:0]);
    assign op        = dq_pkg::kind_t'(kind);
    // front ops hit the low end unless reversed; back ops the opposite
    assign to_low    = ((op == dq_pkg::KIND_PUSH_FRONT) || (op == dq_pkg::KIND_POP_FRONT))
                       ^ rev_reg;

    // operation decode and pointer update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        stat_next  = stat_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_slot;
        if (cmd.exec)
        begin
            stat_next = dq_pkg::STAT_DONE;
            case (op)
                dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        stat_next = dq_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (to_low)
                        begin
                            head_next = head_dec;
                            wr_addr   = head_dec;
                        end
                    end
                end
                dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        stat_next = dq_pkg::STAT_UNDERFLOW;
                    end
                    else
                    begin
                        count_next = cnt_m1;
                        if (to_low)
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                dq_pkg::KIND_CLEAR:
                begin
                    head_next  = '0;
                    count_next = '0;
                    rev_next   = 1'b0;
                end
                dq_pkg::KIND_REVERSE:
                begin
                    rev_next = ~rev_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            stat_reg      <= dq_pkg::STAT_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // word store, one write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            word_store[wr_addr] <= value;
        end
        if (cmd.read)
        begin
            lo_q_reg <= word_store[head_reg];
            hi_q_reg <= word_store[hi_slot];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (empty)
            begin
                front_reg <= '1;
                back_reg  <= '1;
            end
            else if (rev_reg)
            begin
                front_reg <= hi_q_reg;
                back_reg  <= lo_q_reg;
            end
            else
            begin
                front_reg <= lo_q_reg;
                back_reg  <= hi_q_reg;
            end
            occ_reg    <= count_reg;
            empty_reg  <= empty;
            status_reg <= stat_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;
    assign occupancy   = occ_reg;
    assign is_empty    = empty_reg;
    assign status      = status_reg;

endmodule

>>> sv/double_ended_queue_top.sv
// top level of the double-ended queue: stream ports, controller and datapath
// depends on dq_pkg, dq_ctrl, dq_datapath and double_ended_queue_top_assert.svh
//
//   channel   dir   payload
//   s_*       in    tuser: kind[2:0]; tdata: value[31:0]
//   m_*       out   tdata: front_value, back_value, occupancy, is_empty, status
//
// each transaction runs through accept and pointer update, store read and
// result load; the two-port word store read sits between update and load
// the result register frees the sequencer, so the next transaction is taken
// while a result still waits, and a held result only stalls the load step
// reset (rst_n low, asynchronous) empties the queue; the store needs no clearing
`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top #(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [2:0] s_tuser,        // kind[2:0]
    input  logic [31:0] s_tdata,       // value[31:0]
    output logic m_tvalid,
    input  logic m_tready,
    // front_value[31:0], back_value[63:32], occupancy, is_empty, status, zero fill
    output logic [(((67 + $clog2(CAPACITY + 1)) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = (((67 + CNT_W) + 7) / 8) * 8;

    dq_pkg::dq_cmd_t    cmd;
    dq_pkg::dq_sts_t    sts;
    logic signed [31:0] front_value, back_value;
    logic [CNT_W-1:0]   occupancy;
    logic               is_empty;
    logic [1:0]         status;

    // sequencer
    dq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // pointers, store and result register
    dq_datapath #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W),
        .CNT_W    (CNT_W)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (s_tuser),
        .value       (s_tdata),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .front_value (front_value),
        .back_value  (back_value),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .status      (status)
    );

    // result packing, low field first
    assign m_tdata = OUT_W'({status, is_empty, occupancy, back_value, front_value});

    // checks
    `DQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `DQ_ASSERT_IMPL(a_occ_bound, m_tvalid, occupancy <= CNT_W'(CAPACITY))
    `DQ_ASSERT_IMPL(a_empty_match, m_tvalid, is_empty == (occupancy == '0))
    `DQ_ASSERT_IMPL(a_empty_ones, m_tvalid && is_empty, (&front_value) && (&back_value))
    `DQ_ASSERT_IMPL(a_drop_when_full, m_tvalid && (status == dq_pkg::STAT_OVERFLOW),
        occupancy == CNT_W'(CAPACITY))

endmodule

>>> dv/tb_double_ended_queue_top.sv
// self-checking testbench for double_ended_queue_top: stream stimulus, result checks
// depends on dq_pkg and double_ended_queue_top; nothing else is read at run time
`timescale 1ns / 100ps

module tb_double_ended_queue_top;

    localparam int CAPACITY = 16;
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int RES_W = (((67 + $clog2(CAPACITY + 1)) + 7) / 8) * 8;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    // one queue operation as sent on the input stream
    typedef struct {
        logic [2:0] op;
        logic [31:0] word;
    } dq_op_t;

    // queue view reported after each operation
    typedef struct packed {
        logic [31:0] front_word;
        logic [31:0] back_word;
        logic [OCC_W-1:0] occupancy;
        logic is_empty;
        dq_pkg::stat_t status;
    } dq_view_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [2:0] s_tuser;       // kind[2:0]
    logic [31:0] s_tdata;      // value[31:0]
    logic m_tvalid;
    logic m_tready;
    // front_value[31:0], back_value[63:32], occupancy, is_empty, status, zero fill
    logic [RES_W-1:0] m_tdata;

    dq_op_t pending_ops[$];
    dq_view_t expected_views[$];

    // shadow copy of the queue contents
    logic [31:0] shadow_store [CAPACITY];
    int unsigned shadow_head;
    int unsigned shadow_count;
    bit shadow_reversed;

    int fail_count;
    bit in_taken;
    int burst_left;
    int gap_left;
    int unsigned rx_cycle;
    int idle_cycles;

    double_ended_queue_top #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // insert at the physical low or high end; returns the status code
    function automatic dq_pkg::stat_t shadow_push(bit at_low, logic [31:0] word);
        if (shadow_count >= CAPACITY)
            return dq_pkg::STAT_OVERFLOW;
        if (at_low)
        begin
            shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
            shadow_store[shadow_head] = word;
        end
        else
        begin
            shadow_store[(shadow_head + shadow_count) % CAPACITY] = word;
        end
        shadow_count++;
        return dq_pkg::STAT_DONE;
    endfunction

    // remove from the physical low or high end; returns the status code
    function automatic dq_pkg::stat_t shadow_pop(bit at_low);
        if (shadow_count == 0)
            return dq_pkg::STAT_UNDERFLOW;
        if (at_low)
            shadow_head = (shadow_head + 1) % CAPACITY;
        shadow_count--;
        return dq_pkg::STAT_DONE;
    endfunction

    // apply one operation to the shadow queue and return the view it reports
    function automatic dq_view_t apply_deque_op(logic [2:0] op, logic [31:0] word);
        dq_view_t view;
        bit front_low;
        logic [31:0] low_word;
        logic [31:0] high_word;
        front_low = !shadow_reversed;
        view.status = dq_pkg::STAT_DONE;
        case (op)
            dq_pkg::KIND_PUSH_FRONT: view.status = shadow_push(front_low, word);
            dq_pkg::KIND_PUSH_BACK:  view.status = shadow_push(!front_low, word);
            dq_pkg::KIND_POP_FRONT:  view.status = shadow_pop(front_low);
            dq_pkg::KIND_POP_BACK:   view.status = shadow_pop(!front_low);
            dq_pkg::KIND_CLEAR:
            begin
                shadow_count = 0;
                shadow_head = 0;
                shadow_reversed = 0;
            end
            dq_pkg::KIND_REVERSE:    shadow_reversed = !shadow_reversed;
            default:                 ;
        endcase
        if (shadow_count == 0)
        begin
            view.front_word = '1;
            view.back_word = '1;
        end
        else
        begin
            low_word = shadow_store[shadow_head % CAPACITY];
            high_word = shadow_store[(shadow_head + shadow_count - 1) % CAPACITY];
            view.front_word = shadow_reversed ? high_word : low_word;
            view.back_word = shadow_reversed ? low_word : high_word;
        end
        view.occupancy = OCC_W'(shadow_count);
        view.is_empty = (shadow_count == 0);
        return view;
    endfunction

    // push word with a bias toward the sign and range extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // operation mix: 0 mostly pushes, 1 mostly pops, 2 even
    function automatic logic [2:0] pick_op(int mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        push_pct = (mix == 0) ? 65 : (mix == 1) ? 20 : 42;
        pop_pct = (mix == 1) ? 65 : (mix == 0) ? 20 : 42;
        if (roll < push_pct)
            return $urandom_range(0, 1) ? dq_pkg::KIND_PUSH_FRONT : dq_pkg::KIND_PUSH_BACK;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? dq_pkg::KIND_POP_FRONT : dq_pkg::KIND_POP_BACK;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return dq_pkg::KIND_REVERSE;
        if (roll < 75)
            return dq_pkg::KIND_QUERY;
        if (roll < 85)
            return KIND_UNUSED;
        return dq_pkg::KIND_CLEAR;
    endfunction

    function automatic void queue_op(logic [2:0] op, logic [31:0] word);
        dq_op_t item;
        item.op = op;
        item.word = word;
        pending_ops.insert(pending_ops.size(), item);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stimulus: directed corner cases, then random phases with a drain after each
    initial
    begin
        int mix;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        fail_count = 0;
        shadow_head = 0;
        shadow_count = 0;
        shadow_reversed = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue: pops, reverse, unused code, query
        queue_op(dq_pkg::KIND_POP_FRONT, 32'h1234_5678);
        queue_op(dq_pkg::KIND_POP_BACK, 32'h0);
        queue_op(dq_pkg::KIND_REVERSE, 32'h0);
        queue_op(KIND_UNUSED, 32'hffff_ffff);
        queue_op(dq_pkg::KIND_QUERY, 32'h0);
        // extreme words at both ends, then reversed pops
        queue_op(dq_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff);
        queue_op(dq_pkg::KIND_PUSH_BACK, 32'h8000_0000);
        queue_op(dq_pkg::KIND_PUSH_FRONT, 32'h0000_0000);
        queue_op(dq_pkg::KIND_PUSH_BACK, 32'hffff_ffff);
        queue_op(dq_pkg::KIND_REVERSE, 32'h0);
        queue_op(dq_pkg::KIND_POP_FRONT, 32'h0);
        queue_op(dq_pkg::KIND_POP_BACK, 32'h0);
        // fill to capacity, then overflow at both ends
        for (int i = 0; i < CAPACITY - 2; i++)
            queue_op(i[0] ? dq_pkg::KIND_PUSH_BACK : dq_pkg::KIND_PUSH_FRONT, $urandom);
        queue_op(dq_pkg::KIND_PUSH_FRONT, $urandom);
        queue_op(dq_pkg::KIND_PUSH_BACK, $urandom);
        queue_op(dq_pkg::KIND_CLEAR, 32'h0);
        while (pending_ops.size() != 0 || expected_views.size() != 0)
            @(posedge clk);

        // random phases; the sender waits for all results after each one
        for (int ph = 0; ph < 12; ph++)
        begin
            mix = ph % 3;
            for (int n = 0; n < 118; n++)
                queue_op(pick_op(mix), pick_word());
            while (pending_ops.size() != 0 || expected_views.size() != 0)
                @(posedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_views.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // input driver: bursts and gaps, valid held until the transaction is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending_ops.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_ops[0].op;
                s_tdata <= pending_ops[0].word;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output ready pattern, cycling through always ready, mostly ready, sparse and random modes
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            case ((rx_cycle / 300) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((rx_cycle % 8) == 0);
                default: m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // monitor: check results against the oldest expectation, then log new inputs
    always @(posedge clk)
    begin
        dq_view_t seen;
        dq_view_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.front_word = m_tdata[31:0];
                seen.back_word = m_tdata[63:32];
                seen.occupancy = m_tdata[64 +: OCC_W];
                seen.is_empty = m_tdata[64 + OCC_W];
                seen.status = dq_pkg::stat_t'(m_tdata[65 + OCC_W +: 2]);
                if (expected_views.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result transaction: %h", m_tdata);
                end
                else
                begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    if (seen.front_word !== want.front_word
                        || seen.back_word !== want.back_word
                        || seen.occupancy !== want.occupancy
                        || seen.is_empty !== want.is_empty
                        || seen.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch exp %h %h %0d %0d %0d got %h %h %0d %0d %0d",
                                want.front_word, want.back_word, want.occupancy,
                                want.is_empty, want.status, seen.front_word,
                                seen.back_word, seen.occupancy, seen.is_empty,
                                seen.status);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_views.insert(expected_views.size(), apply_deque_op(s_tuser, s_tdata));
                pending_ops.delete(0);
                in_taken = 1'b1;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
+incdir+sv
sv/dq_pkg.sv
sv/dq_ctrl.sv
sv/dq_datapath.sv
sv/double_ended_queue_top.sv
dv/tb_double_ended_queue_top.sv
